// ----- hdl/cdod_pkg.sv -----
package cdod_pkg;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int ACC_W   = 17;

  localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
  localparam logic [YEAR_W-1:0]  YEAR_OVER  = 14'd10000;
  localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST  = 5'd1;
  localparam logic [DAY_W-1:0]   DAYS_LONG  = 5'd31;

  // Multiplicative inverse of 25 modulo 2^14 and the divisibility limit that goes with it.
  localparam logic [YEAR_W-1:0]  INV25      = 14'd7209;
  localparam logic [YEAR_W-1:0]  DIV25_LIM  = 14'd655;

  localparam logic OP_SHIFT = 1'b0;
  localparam logic OP_DIFF  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_A,
    ST_CHK_B,
    ST_ORDER,
    ST_WALK,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    STEP_FWD,
    STEP_BACK,
    STEP_DIFF
  } step_mode_t;

  typedef struct packed {
    step_mode_t           mode;
    logic [YEAR_W-1:0]    year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;
    logic [ACC_W-1:0]     acc;
    logic [YEAR_W-1:0]    tgt_year;
    logic [MONTH_W-1:0]   tgt_month;
    logic [DAY_W-1:0]     tgt_day;
  } step_req_t;

  typedef struct packed {
    logic [YEAR_W-1:0]    year;
    logic [MONTH_W-1:0]   month;
    logic [DAY_W-1:0]     day;
    logic [ACC_W-1:0]     acc;
    logic                 fin;
    logic [DAY_W-1:0]     dim;
  } step_rsp_t;

  // Gregorian leap rule. Divisibility by 25 uses the modular inverse test, and
  // divisibility by 100 or 400 follows from it together with the low bits.
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [YEAR_W-1:0] p;
    logic              div25;
    p     = y * INV25;
    div25 = (p <= DIV25_LIM);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic leap,
                                                  input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      4'd2:                                       d = leap ? 5'd29 : 5'd28;
      default:                                    d = 5'd0;
    endcase
    return d;
  endfunction

endpackage

// ----- hdl/calendar_date_offset_and_difference_core.sv -----
// Gregorian date engine. Each input beat carries a date and either a signed
// day offset (op 0, shift the date) or a second date (op 1, count the days
// between them). Exactly one result beat comes out per input beat. The block
// handles one item at a time: it walks the calendar one month per clock
// through a single shared month-step unit, so a shift walks through the
// month boundaries that it crosses, and a difference walks through the
// months between the two dates and stops where the running count passes
// the saturation bound. Invalid dates, years outside 1..9999, offsets beyond
// MAX_OFFSET and shifts that leave the year range set out_error with the
// date fields zero; a difference above min(MAX_OFFSET, 65535) saturates
// out_day_count and sets out_error while out_first_later stays meaningful.
// A finished result moves into an output register once that register is
// free, and the next input beat can be taken after that even if the result
// has not yet left.
module calendar_date_offset_and_difference_core #(
  parameter int MAX_OFFSET = 65535
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [13:0]        in_year,
  input  logic [3:0]         in_month,
  input  logic [4:0]         in_day,
  input  logic signed [16:0] in_offset,
  input  logic [13:0]        in_other_year,
  input  logic [3:0]         in_other_month,
  input  logic [4:0]         in_other_day,

  output logic               out_valid,
  input  logic               out_stall,
  output logic [13:0]        out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day,
  output logic [15:0]        out_day_count,
  output logic               out_first_later,
  output logic               out_error
);
  import cdod_pkg::*;

  // The offset bound is compared at 23 bits; the difference
  // bound never exceeds the 16-bit count.
  localparam int               BOUND_INT = (MAX_OFFSET < 65535) ? MAX_OFFSET : 65535;
  localparam logic [22:0]      MaxOff    = 23'(MAX_OFFSET);
  localparam logic [ACC_W-1:0] Bound     = ACC_W'(BOUND_INT);

  state_t              state_r, state_nxt;
  logic                op_r, op_nxt;
  logic                back_r, back_nxt;
  logic [YEAR_W-1:0]   yr_r, yr_nxt;
  logic [MONTH_W-1:0]  mo_r, mo_nxt;
  logic [DAY_W-1:0]    dy_r, dy_nxt;
  logic [YEAR_W-1:0]   ty_r, ty_nxt;
  logic [MONTH_W-1:0]  tm_r, tm_nxt;
  logic [DAY_W-1:0]    td_r, td_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic                later_r, later_nxt;
  logic                err_r, err_nxt;

  logic                ovalid_r, ovalid_nxt;
  logic [13:0]         oyear_r, oyear_nxt;
  logic [3:0]          omonth_r, omonth_nxt;
  logic [4:0]          oday_r, oday_nxt;
  logic [15:0]         ocount_r, ocount_nxt;
  logic                olater_r, olater_nxt;
  logic                oerr_r, oerr_nxt;

  step_req_t           req;
  step_rsp_t           rsp;
  logic                date_ok;
  logic [ACC_W-1:0]    mag;
  logic                out_free;

  // The shared unit always works on the working date; the target date is
  // only consulted in difference mode.
  always_comb begin
    req.year      = yr_r;
    req.month     = mo_r;
    req.day       = dy_r;
    req.acc       = acc_r;
    req.tgt_year  = ty_r;
    req.tgt_month = tm_r;
    req.tgt_day   = td_r;
    if (op_r == OP_DIFF) begin
      req.mode = STEP_DIFF;
    end else if (back_r) begin
      req.mode = STEP_BACK;
    end else begin
      req.mode = STEP_FWD;
    end
  end

  cdod_step u_step (
    .req (req),
    .rsp (rsp)
  );

  assign date_ok = (yr_r != '0) && (yr_r <= YEAR_MAX) &&
                   (mo_r != '0) && (mo_r <= MONTH_DEC) &&
                   (dy_r != '0) && (dy_r <= rsp.dim);

  // Two's complement magnitude; the most negative offset yields 65536, which
  // still fits the unsigned 17-bit field.
  assign mag      = in_offset[16] ? (~in_offset + 17'd1) : in_offset;
  assign out_free = !ovalid_r || !out_stall;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    back_nxt   = back_r;
    yr_nxt     = yr_r;
    mo_nxt     = mo_r;
    dy_nxt     = dy_r;
    ty_nxt     = ty_r;
    tm_nxt     = tm_r;
    td_nxt     = td_r;
    acc_nxt    = acc_r;
    later_nxt  = later_r;
    err_nxt    = err_r;
    ovalid_nxt = ovalid_r && out_stall;
    oyear_nxt  = oyear_r;
    omonth_nxt = omonth_r;
    oday_nxt   = oday_r;
    ocount_nxt = ocount_r;
    olater_nxt = olater_r;
    oerr_nxt   = oerr_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          back_nxt  = in_offset[16];
          yr_nxt    = in_year;
          mo_nxt    = in_month;
          dy_nxt    = in_day;
          ty_nxt    = in_other_year;
          tm_nxt    = in_other_month;
          td_nxt    = in_other_day;
          acc_nxt   = (in_op == OP_SHIFT) ? mag : '0;
          later_nxt = 1'b0;
          err_nxt   = 1'b0;
          state_nxt = ST_CHK_A;
        end
      end
      ST_CHK_A: begin
        if (!date_ok) begin
          err_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end else if (op_r == OP_SHIFT) begin
          if ({6'b0, acc_r} > MaxOff) begin
            err_nxt   = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_WALK;
          end
        end else begin
          // Swap so that the second date can be checked by the same unit.
          yr_nxt    = ty_r;
          mo_nxt    = tm_r;
          dy_nxt    = td_r;
          ty_nxt    = yr_r;
          tm_nxt    = mo_r;
          td_nxt    = dy_r;
          state_nxt = ST_CHK_B;
        end
      end
      ST_CHK_B: begin
        if (!date_ok) begin
          err_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_ORDER;
        end
      end
      ST_ORDER: begin
        // The target now holds the first date. The walk always runs forward
        // from the earlier date, so swap back when the first date is not later.
        if ({ty_r, tm_r, td_r} > {yr_r, mo_r, dy_r}) begin
          later_nxt = 1'b1;
        end else begin
          yr_nxt = ty_r;
          mo_nxt = tm_r;
          dy_nxt = td_r;
          ty_nxt = yr_r;
          tm_nxt = mo_r;
          td_nxt = dy_r;
        end
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (op_r == OP_SHIFT) begin
          if (acc_r == '0) begin
            state_nxt = ST_FIN;
          end else begin
            yr_nxt  = rsp.year;
            mo_nxt  = rsp.month;
            dy_nxt  = rsp.day;
            acc_nxt = rsp.acc;
            if ((rsp.year == '0) || (rsp.year == YEAR_OVER)) begin
              err_nxt   = 1'b1;
              state_nxt = ST_FIN;
            end
          end
        end else begin
          yr_nxt  = rsp.year;
          mo_nxt  = rsp.month;
          dy_nxt  = rsp.day;
          acc_nxt = rsp.acc;
          if (rsp.acc > Bound) begin
            acc_nxt   = Bound;
            err_nxt   = 1'b1;
            state_nxt = ST_FIN;
          end else if (rsp.fin) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          if ((op_r == OP_SHIFT) && !err_r) begin
            oyear_nxt  = yr_r;
            omonth_nxt = mo_r;
            oday_nxt   = dy_r;
          end else begin
            oyear_nxt  = '0;
            omonth_nxt = '0;
            oday_nxt   = '0;
          end
          ocount_nxt = (op_r == OP_DIFF) ? acc_r[15:0] : 16'd0;
          olater_nxt = (op_r == OP_DIFF) ? later_r : 1'b0;
          oerr_nxt   = err_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    back_r   <= back_nxt;
    yr_r     <= yr_nxt;
    mo_r     <= mo_nxt;
    dy_r     <= dy_nxt;
    ty_r     <= ty_nxt;
    tm_r     <= tm_nxt;
    td_r     <= td_nxt;
    acc_r    <= acc_nxt;
    later_r  <= later_nxt;
    err_r    <= err_nxt;
    oyear_r  <= oyear_nxt;
    omonth_r <= omonth_nxt;
    oday_r   <= oday_nxt;
    ocount_r <= ocount_nxt;
    olater_r <= olater_nxt;
    oerr_r   <= oerr_nxt;
  end

  assign out_valid       = ovalid_r;
  assign out_year        = oyear_r;
  assign out_month       = omonth_r;
  assign out_day         = oday_r;
  assign out_day_count   = ocount_r;
  assign out_first_later = olater_r;
  assign out_error       = oerr_r;

endmodule

// ----- hdl/cdod_step.sv -----
module cdod_step (
  input  cdod_pkg::step_req_t req,
  output cdod_pkg::step_rsp_t rsp
);
  import cdod_pkg::*;

  logic                leap;
  logic [DAY_W-1:0]    dim;
  logic [DAY_W-1:0]    dim_prev;
  logic [DAY_W:0]      to_end;
  logic [MONTH_W-1:0]  next_month;
  logic [YEAR_W-1:0]   next_year;
  logic [MONTH_W-1:0]  prev_month;
  logic [YEAR_W-1:0]   prev_year;
  logic                same_month;

  always_comb begin
    leap       = is_leap(req.year);
    dim        = month_days(leap, req.month);
    dim_prev   = (req.month == MONTH_JAN) ? DAYS_LONG : month_days(leap, req.month - 4'd1);
    to_end     = {1'b0, dim} - {1'b0, req.day} + 6'd1;
    next_month = (req.month == MONTH_DEC) ? MONTH_JAN : req.month + 4'd1;
    next_year  = (req.month == MONTH_DEC) ? req.year + 14'd1 : req.year;
    prev_month = (req.month == MONTH_JAN) ? MONTH_DEC : req.month - 4'd1;
    prev_year  = (req.month == MONTH_JAN) ? req.year - 14'd1 : req.year;
    same_month = (req.year == req.tgt_year) && (req.month == req.tgt_month);

    rsp.year  = req.year;
    rsp.month = req.month;
    rsp.day   = req.day;
    rsp.acc   = req.acc;
    rsp.fin   = 1'b0;
    rsp.dim   = dim;

    case (req.mode)
      STEP_FWD: begin
        if (req.acc >= ACC_W'(to_end)) begin
          rsp.acc   = req.acc - ACC_W'(to_end);
          rsp.year  = next_year;
          rsp.month = next_month;
          rsp.day   = DAY_FIRST;
        end else begin
          rsp.acc = '0;
          rsp.day = req.day + req.acc[DAY_W-1:0];
        end
      end
      STEP_BACK: begin
        if (req.acc >= ACC_W'(req.day)) begin
          rsp.acc   = req.acc - ACC_W'(req.day);
          rsp.year  = prev_year;
          rsp.month = prev_month;
          rsp.day   = dim_prev;
        end else begin
          rsp.acc = '0;
          rsp.day = req.day - req.acc[DAY_W-1:0];
        end
      end
      STEP_DIFF: begin
        if (same_month) begin
          rsp.acc = req.acc + ACC_W'(req.tgt_day - req.day);
          rsp.day = req.tgt_day;
          rsp.fin = 1'b1;
        end else begin
          rsp.acc   = req.acc + ACC_W'(to_end);
          rsp.year  = next_year;
          rsp.month = next_month;
          rsp.day   = DAY_FIRST;
        end
      end
      default: begin
        rsp.fin = 1'b1;
      end
    endcase
  end

endmodule

// ----- dv/tb.sv -----
module tb;
  import cdod_pkg::*;

  // The block is built with its default offset bound. The day count
  // saturates at the smaller of that bound and the 16-bit maximum.
  localparam int SHIFT_LIMIT = 65535;
  localparam int COUNT_BOUND = (SHIFT_LIMIT < 65535) ? SHIFT_LIMIT : 65535;

  // One input beat: a date plus either an offset (shift) or a second date
  // (difference). The fields that the operation ignores still carry random
  // bits so that the block is seen to ignore them.
  typedef struct packed {
    logic                      op;
    logic [YEAR_W-1:0]         year;
    logic [MONTH_W-1:0]        month;
    logic [DAY_W-1:0]          day;
    logic signed [ACC_W-1:0]   offset;
    logic [YEAR_W-1:0]         other_year;
    logic [MONTH_W-1:0]        other_month;
    logic [DAY_W-1:0]          other_day;
  } date_item_t;

  // One result beat as the block should present it.
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [15:0]        day_count;
    logic               first_later;
    logic               error;
  } calendar_answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_op = OP_SHIFT;
  logic [13:0]        in_year = '0;
  logic [3:0]         in_month = '0;
  logic [4:0]         in_day = '0;
  logic signed [16:0] in_offset = '0;
  logic [13:0]        in_other_year = '0;
  logic [3:0]         in_other_month = '0;
  logic [4:0]         in_other_day = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [13:0]        out_year;
  logic [3:0]         out_month;
  logic [4:0]         out_day;
  logic [15:0]        out_day_count;
  logic               out_first_later;
  logic               out_error;

  // Answers predicted for accepted beats, oldest first.
  calendar_answer_t calendar_answers[$];
  calendar_answer_t oldest_answer;
  int fault_count = 0;
  int answers_checked = 0;

  // Sender pacing: bursts of beats separated by idle gaps, switchable so
  // that some stretches run back to back.
  int burst_left = 0;
  bit idle_gaps = 1'b1;

  // A nonzero value asks the receiver to hold off for that many cycles.
  int hold_request = 0;

  calendar_date_offset_and_difference_core #(
    .MAX_OFFSET(SHIFT_LIMIT)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_year        (in_year),
    .in_month       (in_month),
    .in_day         (in_day),
    .in_offset      (in_offset),
    .in_other_year  (in_other_year),
    .in_other_month (in_other_month),
    .in_other_day   (in_other_day),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_year       (out_year),
    .out_month      (out_month),
    .out_day        (out_day),
    .out_day_count  (out_day_count),
    .out_first_later(out_first_later),
    .out_error      (out_error)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Calendar arithmetic used to predict each answer. Dates are turned into
  // a running day number counted from 0001-01-01, moved or compared there,
  // and turned back into a date where needed.
  // ---------------------------------------------------------------------

  // A year is leap when divisible by 4, except centuries not divisible by 400.
  function automatic bit leap_rule(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int month_length(input int y, input int m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return leap_rule(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic bit legal_date(input int y, input int m, input int d);
    if (y < 1 || y > 9999 || m < 1 || m > 12) return 1'b0;
    return (d >= 1) && (d <= month_length(y, m));
  endfunction

  function automatic int day_number(input int y, input int m, input int d);
    int prior;
    int n;
    prior = y - 1;
    n = 365 * prior + prior / 4 - prior / 100 + prior / 400;
    for (int k = 1; k < m; k++) n += month_length(y, k);
    return n + d - 1;
  endfunction

  // The year is first estimated from the mean Gregorian year length and then
  // nudged until its first day is the last one not after n.
  function automatic void date_from_number(input int n, output int y, output int m,
                                           output int d);
    int rest;
    y = (n * 400) / 146097 + 1;
    while (y > 1 && day_number(y, 1, 1) > n) y--;
    while (day_number(y + 1, 1, 1) <= n) y++;
    rest = n - day_number(y, 1, 1);
    m = 1;
    while (m < 12 && rest >= month_length(y, m)) begin
      rest -= month_length(y, m);
      m++;
    end
    d = rest + 1;
  endfunction

  function automatic calendar_answer_t calendar_answer(input date_item_t it);
    calendar_answer_t a;
    int y1, m1, d1, y2, m2, d2;
    int shift, n1, n2, span, ry, rm, rd;
    a  = '0;
    y1 = it.year;
    m1 = it.month;
    d1 = it.day;
    if (it.op == OP_SHIFT) begin
      shift = $signed(it.offset);
      if (!legal_date(y1, m1, d1) || shift > SHIFT_LIMIT || -shift > SHIFT_LIMIT) begin
        a.error = 1'b1;
      end else begin
        n1 = day_number(y1, m1, d1) + shift;
        // Leaving the year range is an error with all date fields zero.
        if (n1 < 0 || n1 > day_number(9999, 12, 31)) begin
          a.error = 1'b1;
        end else begin
          date_from_number(n1, ry, rm, rd);
          a.year  = ry[YEAR_W-1:0];
          a.month = rm[MONTH_W-1:0];
          a.day   = rd[DAY_W-1:0];
        end
      end
    end else begin
      y2 = it.other_year;
      m2 = it.other_month;
      d2 = it.other_day;
      if (!legal_date(y1, m1, d1) || !legal_date(y2, m2, d2)) begin
        a.error = 1'b1;
      end else begin
        n1 = day_number(y1, m1, d1);
        n2 = day_number(y2, m2, d2);
        a.first_later = (n1 > n2);
        span = (n1 > n2) ? n1 - n2 : n2 - n1;
        // A saturated count is flagged, but the direction still holds.
        if (span > COUNT_BOUND) begin
          span    = COUNT_BOUND;
          a.error = 1'b1;
        end
        a.day_count = span[15:0];
      end
    end
    return a;
  endfunction

  // ---------------------------------------------------------------------
  // Beat construction and random dates.
  // ---------------------------------------------------------------------

  function automatic date_item_t shift_item(input int y, input int m, input int d,
                                            input int off);
    date_item_t it;
    it.op          = OP_SHIFT;
    it.year        = y[YEAR_W-1:0];
    it.month       = m[MONTH_W-1:0];
    it.day         = d[DAY_W-1:0];
    it.offset      = off[ACC_W-1:0];
    it.other_year  = YEAR_W'($urandom);
    it.other_month = MONTH_W'($urandom);
    it.other_day   = DAY_W'($urandom);
    return it;
  endfunction

  function automatic date_item_t diff_item(input int y, input int m, input int d,
                                           input int y2, input int m2, input int d2);
    date_item_t it;
    it.op          = OP_DIFF;
    it.year        = y[YEAR_W-1:0];
    it.month       = m[MONTH_W-1:0];
    it.day         = d[DAY_W-1:0];
    it.offset      = ACC_W'($urandom);
    it.other_year  = y2[YEAR_W-1:0];
    it.other_month = m2[MONTH_W-1:0];
    it.other_day   = d2[DAY_W-1:0];
    return it;
  endfunction

  // Mostly legal dates, leaning toward century years, month ends and the
  // edges of the year range. With allow_bad a share of them is broken in the
  // year, the month or the day.
  function automatic void pick_date(input bit allow_bad, output int y, output int m,
                                    output int d);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      y = $urandom_range(1, 9999);
    end else if (sel < 75) begin
      y = $urandom_range(1890, 2110);
    end else if (sel < 90) begin
      case ($urandom_range(0, 7))
        0:       y = 1;
        1:       y = 4;
        2:       y = 100;
        3:       y = 400;
        4:       y = 1900;
        5:       y = 2000;
        6:       y = 2100;
        default: y = $urandom_range(9990, 9999);
      endcase
    end else begin
      y = $urandom_range(1, 40);
    end
    m   = $urandom_range(1, 12);
    sel = $urandom_range(0, 9);
    if (sel == 0) d = 1;
    else if (sel == 1) d = month_length(y, m);
    else d = $urandom_range(1, month_length(y, m));
    if (allow_bad && $urandom_range(0, 99) < 12) begin
      case ($urandom_range(0, 3))
        0: y = $urandom_range(0, 1) ? 0 : $urandom_range(10000, 16383);
        1: m = $urandom_range(0, 1) ? 0 : $urandom_range(13, 15);
        2: d = $urandom_range(0, 1) ? 0 : $urandom_range(month_length(y, m) + 1, 31);
        default: begin
          y = $urandom_range(0, 16383);
          m = $urandom_range(0, 15);
          d = $urandom_range(0, 31);
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------
  // Driving, checking and reporting.
  // ---------------------------------------------------------------------

  task automatic report_fault(input string msg);
    fault_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Offers one beat and returns at the edge where it is taken. Must be called
  // right after a rising edge. A gap lowers valid first, so valid is never
  // lowered and raised in the same step.
  task automatic offer_item(input date_item_t it);
    int pause;
    if (idle_gaps && burst_left == 0) begin
      pause = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    if (burst_left > 0) burst_left--;
    in_valid       <= 1'b1;
    in_op          <= it.op;
    in_year        <= it.year;
    in_month       <= it.month;
    in_day         <= it.day;
    in_offset      <= it.offset;
    in_other_year  <= it.other_year;
    in_other_month <= it.other_month;
    in_other_day   <= it.other_day;
    do @(posedge clk); while (in_stall);
    calendar_answers.push_back(calendar_answer(it));
  endtask

  // Stops offering and waits until every predicted answer has come out.
  task automatic wait_for_answers();
    in_valid <= 1'b0;
    while (calendar_answers.size() != 0) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      report_fault($sformatf("result %0d field %s: got %0d, expected %0d",
                             answers_checked, name, got, want));
  endtask

  // Every result beat is matched against the oldest outstanding answer.
  // Signals are read in the active region of the edge, so they hold the
  // values from before it.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (calendar_answers.size() == 0) begin
        report_fault($sformatf("result beat with no item outstanding: %0d-%0d-%0d count %0d",
                               out_year, out_month, out_day, out_day_count));
      end else begin
        oldest_answer = calendar_answers.pop_front();
        compare_field("year", out_year, oldest_answer.year);
        compare_field("month", out_month, oldest_answer.month);
        compare_field("day", out_day, oldest_answer.day);
        compare_field("day_count", out_day_count, oldest_answer.day_count);
        compare_field("first_later", out_first_later, oldest_answer.first_later);
        compare_field("error", out_error, oldest_answer.error);
      end
      answers_checked++;
    end
  end

  // Receiver: switches between no stalls, random stalls and a fixed duty
  // pattern, and takes a long hold-off on request.
  initial begin : receiver_stalls
    int stall_style;
    int style_left;
    int held;
    stall_style = 0;
    style_left  = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        held         = hold_request;
        hold_request = 0;
        out_stall <= 1'b1;
        repeat (held) @(posedge clk);
      end
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 2);
        style_left  = $urandom_range(50, 300);
      end
      style_left--;
      case (stall_style)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 99) < 35);
        default: out_stall <= ((style_left % 9) < 4);
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  task automatic apply_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // Leap days, century years, month and year rollover, the backward walk
  // landing on the last day of a month after starting on the first, both ends of the year range and both
  // ends of the offset range.
  task automatic test_shift_corners();
    offer_item(shift_item(2024, 2, 28, 1));
    offer_item(shift_item(2023, 2, 28, 1));
    offer_item(shift_item(1900, 2, 28, 1));
    offer_item(shift_item(2000, 2, 28, 1));
    offer_item(shift_item(2024, 3, 1, -1));
    offer_item(shift_item(2023, 12, 31, 1));
    offer_item(shift_item(2024, 5, 10, 0));
    offer_item(shift_item(1, 1, 1, -1));
    offer_item(shift_item(9999, 12, 31, 1));
    offer_item(shift_item(1, 1, 1, SHIFT_LIMIT));
    offer_item(shift_item(9999, 12, 31, -SHIFT_LIMIT));
    // The most negative raw offset lies just beyond the bound.
    offer_item(shift_item(2000, 1, 1, -65536));
  endtask

  // Equal dates, both directions, the count exactly at the bound, one day
  // past it, and saturation with the first date later.
  task automatic test_difference_corners();
    int y, m, d;
    offer_item(diff_item(2024, 7, 4, 2024, 7, 4));
    offer_item(diff_item(2024, 3, 1, 2024, 2, 28));
    date_from_number(COUNT_BOUND, y, m, d);
    offer_item(diff_item(1, 1, 1, y, m, d));
    date_from_number(COUNT_BOUND + 1, y, m, d);
    offer_item(diff_item(1, 1, 1, y, m, d));
    offer_item(diff_item(9999, 12, 31, 1, 1, 1));
  endtask

  // Broken dates in each field, on both operations and on either date.
  task automatic test_invalid_dates();
    offer_item(shift_item(0, 6, 15, 10));
    offer_item(shift_item(16383, 6, 15, -10));
    offer_item(diff_item(2020, 0, 1, 2020, 1, 1));
    offer_item(diff_item(2020, 1, 1, 2020, 15, 1));
    offer_item(shift_item(2021, 4, 31, 1));
    offer_item(shift_item(2023, 2, 29, 1));
    offer_item(diff_item(1900, 2, 29, 1900, 3, 1));
    offer_item(diff_item(2000, 1, 1, 2100, 2, 29));
    offer_item(shift_item(2020, 1, 0, 5));
  endtask

  // The receiver holds off for a long stretch while beats keep coming, so
  // the block fills and stalls its input. The sender then drains fully.
  task automatic test_stalled_output();
    int y, m, d;
    idle_gaps    = 1'b0;
    hold_request = 400;
    for (int i = 0; i < 8; i++) begin
      pick_date(1'b0, y, m, d);
      offer_item(shift_item(y, m, d, int'($urandom_range(0, 60)) - 30));
    end
    wait_for_answers();
    idle_gaps = 1'b1;
  endtask

  // Mostly legal dates with shifts of every size and differences between
  // near and far dates, plus a share of broken dates and oversize offsets.
  task automatic test_random_traffic(input int count);
    int y, m, d, y2, m2, d2, sel, off, n;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) idle_gaps = ($urandom_range(0, 3) != 0);
      pick_date(1'b1, y, m, d);
      if ($urandom_range(0, 1) == 0) begin
        sel = $urandom_range(0, 99);
        if (sel < 60) off = int'($urandom_range(0, 800)) - 400;
        else if (sel < 85) off = int'($urandom_range(0, 12000)) - 6000;
        else if (sel < 97) off = int'($urandom_range(0, 2 * SHIFT_LIMIT)) - SHIFT_LIMIT;
        else off = int'($urandom_range(0, 131071)) - 65536;
        offer_item(shift_item(y, m, d, off));
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
          y2 = y;
          m2 = m;
          d2 = d;
        end else if (sel < 70 && legal_date(y, m, d)) begin
          n = day_number(y, m, d) + int'($urandom_range(0, 3000)) - 1500;
          if (n >= 0 && n <= day_number(9999, 12, 31)) date_from_number(n, y2, m2, d2);
          else pick_date(1'b0, y2, m2, d2);
        end else begin
          pick_date(1'b1, y2, m2, d2);
        end
        offer_item(diff_item(y, m, d, y2, m2, d2));
      end
    end
  endtask

  initial begin
    apply_reset();
    test_shift_corners();
    test_difference_corners();
    test_invalid_dates();
    test_stalled_output();
    test_random_traffic(236);
    wait_for_answers();
    // Any stray beat after the last answer would still be caught here.
    repeat (40) @(posedge clk);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // The timeout allows for every beat taking the longest walk with the longest
  // stalls many times over.
  initial begin
    #40000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
